// File: hw/rtl/stable_priority_queue_top_assert.svh
// Assertion macros used by the queue's top-level RTL file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue assertion failed");

// Implication checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue assertion failed");

`endif

// File: hw/rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int WORD_W = 32;
    localparam int ENTRY_COUNT_W = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [1:0] opcode;
        word_t      item_value;
        word_t      item_priority;
    } req_t;

    typedef struct packed {
        word_t                    head_value;
        word_t                    head_priority;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     is_empty;
        logic                     is_full;
        logic                     op_error;
    } rsp_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_cell.sv
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int COUNT_W = 5,
    parameter int IDX     = 0
)
(
    input  wire logic               clk,
    input  wire cell_ctrl_t         ctrl,
    input  wire word_t              new_value,
    input  wire word_t              new_prio,
    input  wire logic [COUNT_W-1:0] count,
    input  wire logic               left_keeps,
    input  wire word_t              left_value,
    input  wire word_t              left_prio,
    input  wire word_t              right_value,
    input  wire word_t              right_prio,
    output logic                    keeps,
    output word_t                   value,
    output word_t                   prio
);

    word_t value_reg;
    word_t value_next;
    word_t prio_reg;
    word_t prio_next;
    logic  occupied;

    assign occupied = (count > COUNT_W'(IDX));

    // An entry stays put on insert when its priority is at least the new one,
    // so equal priorities keep their arrival order.
    assign keeps = occupied && (prio_reg >= new_prio);

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.insert)
        begin
            if (!keeps)
            begin
                if (left_keeps)
                begin
                    value_next = new_value;
                    prio_next  = new_prio;
                end
                else
                begin
                    value_next = left_value;
                    prio_next  = left_prio;
                end
            end
        end
        else if (ctrl.remove)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stable_priority_queue_top.sv
// Stable priority queue of CAPACITY signed value/priority pairs.
// A request on the req channel carries an opcode (insert, remove head, or
// query) plus the value and priority used by an insert. Each request gives
// exactly one response on the rsp channel: the head entry, the entry count,
// empty and full flags, and an error flag for a dropped insert or a remove
// on an empty queue. Higher priority leaves first; ties leave in arrival order.
// The entries sit in a row of cells, head in cell 0; on each request every
// cell takes its own, its left or its right neighbor's entry, or the new one.
// A response is registered for each accepted request. Throughput is one
// request per cycle while req_stall is low, as the whole cell row updates at once.
// A two-entry output stage decouples the channels: while a response is
// stalled one more request is still accepted, then req_stall rises until
// the receiver drops rsp_stall.
// Reset empties the queue and invalidates both response slots; entry contents
// are not cleared and are only read below the count.
`default_nettype none
`include "stable_priority_queue_top_assert.svh"

module stable_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic       accept;
    logic       is_ins;
    logic       is_rem;
    logic       full;
    logic       empty;
    logic       do_ins;
    logic       do_rem;
    logic       err;
    cell_ctrl_t ctrl;

    word_t cell_value [CAPACITY];
    word_t cell_prio  [CAPACITY];
    logic  cell_keeps [CAPACITY];

    word_t head_value_next;
    word_t head_prio_next;
    rsp_t  result;

    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    rsp_t skid_reg;
    rsp_t skid_next;
    logic out_free;

    assign accept = req_valid && !req_stall;
    assign is_ins = (req.opcode == OP_INSERT);
    assign is_rem = (req.opcode == OP_REMOVE);
    assign full   = (count_reg == CAP_CNT);
    assign empty  = (count_reg == '0);
    assign do_ins = accept && is_ins && !full;
    assign do_rem = accept && is_rem && !empty;
    assign err    = (is_ins && full) || (is_rem && empty);

    assign ctrl.insert = do_ins;
    assign ctrl.remove = do_rem;

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic  left_keeps;
            word_t left_value;
            word_t left_prio;
            word_t right_value;
            word_t right_prio;

            if (gi == 0)
            begin : g_first
                assign left_keeps = 1'b1;
                assign left_value = req.item_value;
                assign left_prio  = req.item_priority;
            end
            else
            begin : g_inner_left
                assign left_keeps = cell_keeps[gi-1];
                assign left_value = cell_value[gi-1];
                assign left_prio  = cell_prio[gi-1];
            end

            // The last cell is never occupied after a remove, so its
            // refill value does not matter.
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_value[gi];
                assign right_prio  = cell_prio[gi];
            end
            else
            begin : g_inner_right
                assign right_value = cell_value[gi+1];
                assign right_prio  = cell_prio[gi+1];
            end

            spq_cell #(
                .COUNT_W (COUNT_W),
                .IDX     (gi)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_value   (req.item_value),
                .new_prio    (req.item_priority),
                .count       (count_reg),
                .left_keeps  (left_keeps),
                .left_value  (left_value),
                .left_prio   (left_prio),
                .right_value (right_value),
                .right_prio  (right_prio),
                .keeps       (cell_keeps[gi]),
                .value       (cell_value[gi]),
                .prio        (cell_prio[gi])
            );
        end
    endgenerate

    // Head after this request, taken from what cell 0 is about to load.
    always_comb
    begin
        head_value_next = cell_value[0];
        head_prio_next  = cell_prio[0];
        if (do_ins && !cell_keeps[0])
        begin
            head_value_next = req.item_value;
            head_prio_next  = req.item_priority;
        end
        else if (do_rem)
        begin
            head_value_next = cell_value[1];
            head_prio_next  = cell_prio[1];
        end
    end

    always_comb
    begin
        result.head_value    = (count_next == '0) ? '0 : head_value_next;
        result.head_priority = (count_next == '0) ? '0 : head_prio_next;
        result.entry_count   = ENTRY_COUNT_W'(count_next);
        result.is_empty      = (count_next == '0);
        result.is_full       = (count_next == CAP_CNT);
        result.op_error      = err;
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = skid_valid_reg;

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        skid_valid_next = skid_valid_reg;
        rsp_next        = rsp_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                rsp_next        = skid_reg;
                rsp_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                rsp_next       = result;
                rsp_valid_next = 1'b1;
            end
            else
            begin
                rsp_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg  <= rsp_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CAP_CNT)
    `SPQ_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, rsp_valid_reg)
    `SPQ_ASSERT_NEXT(a_full_drop, accept && is_ins && full, count_reg == CAP_CNT)
    `SPQ_ASSERT_NEXT(a_remove_count, do_rem, count_reg == $past(count_reg) - COUNT_W'(1))

endmodule

`default_nettype wire
